>>> hdl/prfe_pkg.sv
// ---------------------------------------------------------------------------
// prfe_pkg: shared types and constants for the relocation fixup engine
// Item codes, relocation type codes and the command record that moves
// from the parser to the command generator.
// ---------------------------------------------------------------------------
package prfe_pkg;

    localparam int WORD_W    = 16;
    localparam int ADDR_W    = 64;
    localparam int DATA_W    = 64;
    localparam int RVA_W     = 32;
    localparam int OFF_W     = 12;
    localparam int PGOFF_W   = RVA_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE = 1'b1;

    localparam logic [3:0] TYPE_HIGH    = 4'd1;
    localparam logic [3:0] TYPE_LOW     = 4'd2;
    localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
    localparam logic [3:0] TYPE_DIR64   = 4'd10;

    localparam logic [1:0] PW_64 = 2'd0;
    localparam logic [1:0] PW_32 = 2'd1;
    localparam logic [1:0] PW_16 = 2'd2;

    typedef enum logic [1:0] {
        KIND_PATCH     = 2'd0,
        KIND_END       = 2'd1,
        KIND_MALFORMED = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SEL_DIR64,
        SEL_HIGHLOW,
        SEL_HIGH,
        SEL_LOW
    } t_sel;

    typedef struct packed {
        t_kind              kind;
        t_sel               sel;
        logic [PGOFF_W-1:0] page_off;
        logic               last;
    } t_cmd;

endpackage

>>> hdl/prfe_if.sv
// ---------------------------------------------------------------------------
// prfe_if: input and output channels of the relocation fixup engine
// Valid/ready channels carrying directory words in and fixup items out.
// ---------------------------------------------------------------------------
interface prfe_in_if;
    logic                          valid;
    logic                          ready;
    logic [prfe_pkg::WORD_W-1:0]   reloc_word;
    logic                          end_of_directory;

    modport source (output valid, output reloc_word, output end_of_directory,
                    input ready);
    modport sink   (input valid, input reloc_word, input end_of_directory,
                    output ready);
endinterface

interface prfe_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    result_kind;
    logic [prfe_pkg::ADDR_W-1:0]   patch_address;
    logic [1:0]                    patch_width;
    logic [prfe_pkg::DATA_W-1:0]   addend;
    logic                          directory_done;

    modport source (output valid, output result_kind, output patch_address,
                    output patch_width, output addend, output directory_done,
                    input ready);
    modport sink   (input valid, input result_kind, input patch_address,
                    input patch_width, input addend, input directory_done,
                    output ready);
endinterface

>>> hdl/pe_relocation_fixup_engine.sv
// An accepted word's item is written into the command queue at the same edge; the output
// register then loads it from the queue once it is free, and holds it until it is taken.
// One directory word per cycle while the command queue has room; words that cause no
// item pass through the parser only. A four-entry command queue and the output register
// hold up to five items under an output stall before intake stops.
// Reset (synchronous, active low): parse state, queue, output valid and both
// configuration registers clear at once; no clearing pass.
// ---------------------------------------------------------------------------
// pe_relocation_fixup_engine: base relocation fixup command generator
// Parses the relocation directory stream and emits patch commands built
// from the destination base and the image base delta.
// ---------------------------------------------------------------------------
module pe_relocation_fixup_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    prfe_in_if.sink                         i_in,
    prfe_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [prfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [prfe_pkg::DATA_W-1:0]     i_cfg_wdata
);
    import prfe_pkg::*;

    logic [DATA_W-1:0]  r_delta;
    logic [ADDR_W-1:0]  r_dest_base;

    logic   push_valid;
    logic   push_ready;
    t_cmd   push_cmd;
    logic   pop;
    logic   pop_valid;
    t_cmd   pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta     <= '0;
            r_dest_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELTA:     r_delta     <= i_cfg_wdata;
                CFG_DEST_BASE: r_dest_base <= i_cfg_wdata;
                default:       r_delta     <= r_delta;
            endcase
        end
    end

    prfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_delta_nz   (r_delta != '0),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    prfe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd)
    );

    prfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop       (pop),
        .i_delta     (r_delta),
        .i_dest_base (r_dest_base),
        .o_out       (o_out)
    );

endmodule

>>> hdl/prfe_front.sv
// ---------------------------------------------------------------------------
// prfe_front: relocation directory parser
// Walks block headers and entries one word per cycle while the queue has room,
// and pushes a command for every word that produces an item.
// ---------------------------------------------------------------------------
module prfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    prfe_in_if.sink         i_in,
    input  logic            i_delta_nz,
    input  logic            i_push_ready,
    output logic            o_push_valid,
    output prfe_pkg::t_cmd  o_push_cmd
);
    import prfe_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ENTRY,
        PH_STOPPED
    } t_phase;

    t_phase             r_phase,   n_phase;
    logic [1:0]         r_hwc,     n_hwc;
    logic [RVA_W-1:0]   r_page,    n_page;
    logic [WORD_W-1:0]  r_size_lo, n_size_lo;
    logic [30:0]        r_left,    n_left;

    logic               accept;
    logic [31:0]        size;
    logic [3:0]         etype;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;
    assign size       = {i_in.reloc_word, r_size_lo};
    assign etype      = i_in.reloc_word[15:12];

    always_comb begin
        n_phase      = r_phase;
        n_hwc        = r_hwc;
        n_page       = r_page;
        n_size_lo    = r_size_lo;
        n_left       = r_left;
        o_push_valid = 1'b0;
        o_push_cmd.kind     = KIND_END;
        o_push_cmd.sel      = SEL_DIR64;
        o_push_cmd.page_off = {1'b0, r_page} + PGOFF_W'(i_in.reloc_word[OFF_W-1:0]);
        o_push_cmd.last     = i_in.end_of_directory;

        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    case (r_hwc)
                        2'd0: begin
                            n_page = {16'h0, i_in.reloc_word};
                            n_hwc  = 2'd1;
                        end
                        2'd1: begin
                            n_page = {i_in.reloc_word, r_page[15:0]};
                            n_hwc  = 2'd2;
                        end
                        2'd2: begin
                            n_size_lo = i_in.reloc_word;
                            n_hwc     = 2'd3;
                        end
                        default: begin
                            n_hwc = 2'd0;
                            if (size == 32'd0) begin
                                n_phase = PH_STOPPED;
                            end else if (size < 32'd8 || size[0]) begin
                                n_phase         = PH_STOPPED;
                                o_push_valid    = 1'b1;
                                o_push_cmd.kind = KIND_MALFORMED;
                            end else begin
                                // entries = (size - 8) / 2 for an even size
                                n_left  = size[31:1] - 31'd4;
                                n_phase = (size[31:1] != 31'd4) ? PH_ENTRY : PH_HEADER;
                            end
                        end
                    endcase
                end
                PH_ENTRY: begin
                    if (i_delta_nz) begin
                        case (etype)
                            TYPE_DIR64: begin
                                o_push_valid    = 1'b1;
                                o_push_cmd.kind = KIND_PATCH;
                                o_push_cmd.sel  = SEL_DIR64;
                            end
                            TYPE_HIGHLOW: begin
                                o_push_valid    = 1'b1;
                                o_push_cmd.kind = KIND_PATCH;
                                o_push_cmd.sel  = SEL_HIGHLOW;
                            end
                            TYPE_HIGH: begin
                                o_push_valid    = 1'b1;
                                o_push_cmd.kind = KIND_PATCH;
                                o_push_cmd.sel  = SEL_HIGH;
                            end
                            TYPE_LOW: begin
                                o_push_valid    = 1'b1;
                                o_push_cmd.kind = KIND_PATCH;
                                o_push_cmd.sel  = SEL_LOW;
                            end
                            default: begin
                                o_push_valid = 1'b0;
                            end
                        endcase
                    end
                    n_left = r_left - 31'd1;
                    if (r_left == 31'd1) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            // last word: always report, then start a fresh directory
            if (i_in.end_of_directory) begin
                o_push_valid = 1'b1;
                n_phase      = PH_HEADER;
                n_hwc        = 2'd0;
                n_page       = '0;
                n_size_lo    = '0;
                n_left       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hwc     <= 2'd0;
            r_page    <= '0;
            r_size_lo <= '0;
            r_left    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hwc     <= n_hwc;
            r_page    <= n_page;
            r_size_lo <= n_size_lo;
            r_left    <= n_left;
        end
    end

endmodule

>>> hdl/prfe_queue.sv
// ---------------------------------------------------------------------------
// prfe_queue: command queue between parser and command generator
// Small FIFO that decouples stalls on the output from word intake.
// ---------------------------------------------------------------------------
module prfe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  prfe_pkg::t_cmd  i_push_cmd,
    output logic            o_push_ready,
    input  logic            i_pop,
    output logic            o_pop_valid,
    output prfe_pkg::t_cmd  o_pop_cmd
);
    import prfe_pkg::*;

    t_cmd               r_mem [QDEPTH];
    logic [QAW-1:0]     r_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr;
    logic [QAW:0]       r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != (QAW+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_valid |-> o_push_ready)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_pop_valid)
        else $error("command popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

>>> hdl/prfe_back.sv
// ---------------------------------------------------------------------------
// prfe_back: fixup command generator
// Pops commands, forms the absolute address and the addend, and holds
// the item in the output register until it is taken.
// ---------------------------------------------------------------------------
module prfe_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pop_valid,
    input  prfe_pkg::t_cmd          i_pop_cmd,
    output logic                    o_pop,
    input  logic [prfe_pkg::DATA_W-1:0] i_delta,
    input  logic [prfe_pkg::ADDR_W-1:0] i_dest_base,
    prfe_out_if.source              o_out
);
    import prfe_pkg::*;

    logic               r_valid;
    logic [1:0]         r_kind;
    logic [ADDR_W-1:0]  r_addr;
    logic [1:0]         r_width;
    logic [DATA_W-1:0]  r_addend;
    logic               r_done;

    logic [ADDR_W-1:0]  n_addr;
    logic [1:0]         n_width;
    logic [DATA_W-1:0]  n_addend;
    logic               load;

    assign load  = i_pop_valid && (!r_valid || o_out.ready);
    assign o_pop = load;

    always_comb begin
        n_addr   = '0;
        n_width  = PW_64;
        n_addend = '0;
        if (i_pop_cmd.kind == KIND_PATCH) begin
            n_addr = i_dest_base + ADDR_W'(i_pop_cmd.page_off);
            case (i_pop_cmd.sel)
                SEL_DIR64: begin
                    n_width  = PW_64;
                    n_addend = i_delta;
                end
                SEL_HIGHLOW: begin
                    n_width  = PW_32;
                    n_addend = {32'h0, i_delta[31:0]};
                end
                SEL_HIGH: begin
                    n_width  = PW_16;
                    n_addend = {48'h0, i_delta[31:16]};
                end
                default: begin
                    n_width  = PW_16;
                    n_addend = {48'h0, i_delta[15:0]};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_pop_cmd.kind;
            r_addr   <= n_addr;
            r_width  <= n_width;
            r_addend <= n_addend;
            r_done   <= i_pop_cmd.last;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.result_kind    = r_kind;
    assign o_out.patch_address  = r_addr;
    assign o_out.patch_width    = r_width;
    assign o_out.addend         = r_addend;
    assign o_out.directory_done = r_done;

    a_nonpatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != KIND_PATCH) |->
            (r_addr == '0 && r_addend == '0 && r_width == PW_64))
        else $error("non-patch item carries patch fields");

endmodule

>>> tb/pe_relocation_fixup_engine_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pe_relocation_fixup_engine_tb: self-checking bench for the fixup engine
// Streams relocation directories (well-formed, truncated, malformed and
// noise) under several delta/base settings and handshake idling patterns.
// A scoreboard tracks the directory parse and checks each fixup item.
// ---------------------------------------------------------------------------

class fixup_scoreboard;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ENTRY,
        PH_STOPPED
    } t_parse_phase;

    typedef struct packed {
        prfe_pkg::t_kind kind;
        logic [63:0]     addr;
        logic [1:0]      width;
        logic [63:0]     addend;
        logic            done;
    } t_fixup;

    logic [63:0]  delta;
    logic [63:0]  dest_base;
    t_parse_phase phase;
    logic [1:0]   hdr_cnt;
    logic [31:0]  page_rva;
    logic [15:0]  size_lo;
    logic [30:0]  entries_left;
    t_fixup       fixup_q[$];
    int           errors;
    int           n_patch;
    int           n_end;
    int           n_malformed;

    function new();
        delta        = '0;
        dest_base    = '0;
        errors       = 0;
        n_patch      = 0;
        n_end        = 0;
        n_malformed  = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        phase        = PH_HEADER;
        hdr_cnt      = '0;
        page_rva     = '0;
        size_lo      = '0;
        entries_left = '0;
    endfunction

    function void set_reg(logic [prfe_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        if (idx == prfe_pkg::CFG_DELTA) begin
            delta = val;
        end else begin
            dest_base = val;
        end
    endfunction

    function int pending();
        return fixup_q.size();
    endfunction

    // Advance the parse by one directory word; queue the item it causes.
    function void note_word(logic [15:0] w, logic is_last);
        logic        emit;
        t_fixup      f;
        logic [31:0] bsize;
        logic [3:0]  rtype;
        emit     = 1'b0;
        f.kind   = prfe_pkg::KIND_END;
        f.addr   = '0;
        f.width  = prfe_pkg::PW_64;
        f.addend = '0;
        case (phase)
            PH_HEADER: begin
                case (hdr_cnt)
                    2'd0: page_rva = {16'h0, w};
                    2'd1: page_rva[31:16] = w;
                    2'd2: size_lo = w;
                    default: begin
                        bsize = {w, size_lo};
                        if (bsize == 32'h0) begin
                            phase = PH_STOPPED;
                        end else if (bsize < 32'd8 || bsize[0]) begin
                            phase  = PH_STOPPED;
                            emit   = 1'b1;
                            f.kind = prfe_pkg::KIND_MALFORMED;
                        end else begin
                            entries_left = 31'((bsize - 32'd8) >> 1);
                            phase = (entries_left != 0) ? PH_ENTRY : PH_HEADER;
                        end
                    end
                endcase
                hdr_cnt = hdr_cnt + 2'd1;
            end
            PH_ENTRY: begin
                rtype = w[15:12];
                if (delta != 64'h0) begin
                    emit = 1'b1;
                    case (rtype)
                        prfe_pkg::TYPE_DIR64: begin
                            f.width  = prfe_pkg::PW_64;
                            f.addend = delta;
                        end
                        prfe_pkg::TYPE_HIGHLOW: begin
                            f.width  = prfe_pkg::PW_32;
                            f.addend = {32'h0, delta[31:0]};
                        end
                        prfe_pkg::TYPE_HIGH: begin
                            f.width  = prfe_pkg::PW_16;
                            f.addend = {48'h0, delta[31:16]};
                        end
                        prfe_pkg::TYPE_LOW: begin
                            f.width  = prfe_pkg::PW_16;
                            f.addend = {48'h0, delta[15:0]};
                        end
                        default: emit = 1'b0;
                    endcase
                    if (emit) begin
                        f.kind = prfe_pkg::KIND_PATCH;
                        f.addr = dest_base + {32'h0, page_rva} + {52'h0, w[11:0]};
                    end
                end
                entries_left = entries_left - 31'd1;
                if (entries_left == 0) phase = PH_HEADER;
            end
            default: ;
        endcase
        if (is_last) begin
            emit = 1'b1;
            clear_parse();
        end
        if (emit) begin
            f.done = is_last;
            case (f.kind)
                prfe_pkg::KIND_PATCH:     n_patch++;
                prfe_pkg::KIND_MALFORMED: n_malformed++;
                default:                  n_end++;
            endcase
            fixup_q.push_back(f);
        end
    endfunction

    function void check_result(logic [1:0] kind, logic [63:0] addr, logic [1:0] width,
                               logic [63:0] addend, logic done);
        t_fixup f;
        if (fixup_q.size() == 0) begin
            $error("unexpected item: result_kind %0d patch_address %h", kind, addr);
            errors++;
            return;
        end
        f = fixup_q.pop_front();
        if (kind !== f.kind) begin
            $error("result_kind: expected %0d, got %0d", f.kind, kind);
            errors++;
        end
        if (addr !== f.addr) begin
            $error("patch_address: expected %h, got %h", f.addr, addr);
            errors++;
        end
        if (width !== f.width) begin
            $error("patch_width: expected %0d, got %0d", f.width, width);
            errors++;
        end
        if (addend !== f.addend) begin
            $error("addend: expected %h, got %h", f.addend, addend);
            errors++;
        end
        if (done !== f.done) begin
            $error("directory_done: expected %0d, got %0d", f.done, done);
            errors++;
        end
    endfunction

endclass

module pe_relocation_fixup_engine_tb;
    import prfe_pkg::*;

    localparam int N_PHASES        = 8;
    localparam int WORDS_PER_PHASE = 190;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_wdata;

    prfe_in_if  in_if ();
    prfe_out_if out_if ();

    pe_relocation_fixup_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    fixup_scoreboard sb;
    logic [15:0]     dir_q[$];
    int              src_idle_pct   = 0;
    int              sink_stall_pct = 0;
    int              quiet_cycles   = 0;
    int              n_dirs         = 0;
    int              n_words        = 0;

    always #5 i_clk = ~i_clk;

    // Result side: check on accept, then pick ready for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.result_kind, out_if.patch_address, out_if.patch_width,
                            out_if.addend, out_if.directory_done);
        end
        out_if.ready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_regs(input logic [63:0] delta, input logic [63:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DELTA;
        i_cfg_wdata <= delta;
        @(posedge i_clk);
        i_cfg_index <= CFG_DEST_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_DELTA, delta);
        sb.set_reg(CFG_DEST_BASE, base);
    endtask

    task automatic send_word(input logic [15:0] w, input logic is_last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_if.valid            <= 1'b1;
        in_if.reloc_word       <= w;
        in_if.end_of_directory <= is_last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_word(w, is_last);
    endtask

    // Hold off the sender until every queued item is out and the pipe is quiet.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_directory();
        for (int i = 0; i < dir_q.size(); i++) begin
            send_word(dir_q[i], i == dir_q.size() - 1);
        end
        n_dirs++;
    endtask

    task automatic push_dword(input logic [31:0] v);
        dir_q.push_back(v[15:0]);
        dir_q.push_back(v[31:16]);
    endtask

    function automatic logic [3:0] pick_type();
        case ($urandom_range(9))
            0, 1:    return TYPE_DIR64;
            2, 3:    return TYPE_HIGHLOW;
            4, 5:    return TYPE_HIGH;
            6, 7:    return TYPE_LOW;
            default: return 4'($urandom);
        endcase
    endfunction

    // Mostly well-formed directories; some end in a bad header, get cut short,
    // or are plain noise.
    task automatic build_directory();
        int          nblk;
        int          nent;
        int          mode;
        int          cut;
        logic [31:0] bsize;
        dir_q.delete();
        mode = $urandom_range(99);
        nblk = $urandom_range(1, 3);
        for (int b = 0; b < nblk; b++) begin
            nent  = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            bsize = 32'(8 + 2 * nent);
            push_dword($urandom);
            push_dword(bsize);
            for (int e = 0; e < nent; e++) dir_q.push_back({pick_type(), 12'($urandom)});
        end
        if (mode < 12) begin
            case ($urandom_range(3))
                0:       bsize = 32'h0;
                1:       bsize = 32'($urandom_range(1, 7));
                2:       bsize = $urandom | 32'h1;
                default: bsize = $urandom;
            endcase
            push_dword($urandom);
            push_dword(bsize);
            repeat ($urandom_range(0, 3)) dir_q.push_back(16'($urandom));
        end else if (mode < 22) begin
            cut = $urandom_range(1, dir_q.size());
            while (dir_q.size() > cut) void'(dir_q.pop_back());
        end else if (mode < 27) begin
            dir_q.delete();
            repeat ($urandom_range(1, 8)) dir_q.push_back(16'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [63:0] delta;
        logic [63:0] base;
        int          sent;
        bit          paused;
        sb = new();
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_index            <= CFG_DELTA;
        i_cfg_wdata            <= '0;
        in_if.valid            <= 1'b0;
        in_if.reloc_word       <= '0;
        in_if.end_of_directory <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every relocation type, absolute and unknown entries, an
        // empty block, odd size, zero size with trailing words, size below 8.
        write_regs(64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_FFFF_F000);
        dir_q = '{16'hFFFF, 16'hFFFF, 16'h0014, 16'h0000,
                  16'hAFFF, 16'h3000, 16'h1ABC, 16'h2123, 16'h0000, 16'hF555,
                  16'h1000, 16'h0000, 16'h0008, 16'h0000,
                  16'h0000, 16'h0000, 16'h0009, 16'h0000};
        send_directory();
        drain();
        dir_q = '{16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h5A5A};
        send_directory();
        dir_q = '{16'h3000, 16'h0000, 16'h0004, 16'h0000};
        send_directory();

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0: begin delta = 64'h0123_4567_89AB_CDEF; base = {$urandom, $urandom}; end
                1: begin delta = 64'h0;                   base = '1;                   end
                2: begin delta = 64'h8000_0000_0000_0000; base = '0;                   end
                3: begin delta = 64'h7FFF_FFFF_FFFF_FFFF; base = '1;                   end
                4: begin delta = '1;                      base = {$urandom, $urandom}; end
                default: begin
                    delta = {$urandom, $urandom};
                    base  = {$urandom, $urandom};
                end
            endcase
            write_regs(delta, base);
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            sent   = 0;
            paused = 1'b0;
            while (sent < WORDS_PER_PHASE) begin
                build_directory();
                send_directory();
                sent += dir_q.size();
                if (!paused && sent >= WORDS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            n_words += sent;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected items never arrived", sb.pending());
            sb.errors++;
        end
        $display("run: %0d directories, %0d random words over %0d delta/base settings",
                 n_dirs, n_words, N_PHASES);
        $display("items: %0d patches, %0d end markers, %0d malformed",
                 sb.n_patch, sb.n_end, sb.n_malformed);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
